### rtl/core/volume_central_difference_defines.svh
// Assertion macros for the volume central-difference block.
// Shared by every RTL file that carries concurrent assertions; no dependencies.
`ifndef VOLUME_CENTRAL_DIFFERENCE_DEFINES_SVH
`define VOLUME_CENTRAL_DIFFERENCE_DEFINES_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define VCD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define VCD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/core/vcd_pkg.sv
// Package for the volume central-difference block: widths, register codes,
// axis codes and the size clamp. No dependencies.
package vcd_pkg;

    localparam int MAX_ROW_DEF     = 64;
    localparam int MAX_ROWS_DEF    = 64;
    localparam int SAMPLE_BITS_DEF = 16;

    localparam int PLANE_LIMIT    = 4096;
    localparam int MIN_SIZE       = 3;
    localparam int SIZE_RESET     = 64;
    localparam int Z_BITS         = 12;
    localparam int SZ_BITS        = 13;
    localparam int SIZE_XY_BITS   = 7;
    localparam int AXIS_BITS      = 2;
    localparam int CFG_INDEX_BITS = 2;
    localparam int CFG_DATA_BITS  = 13;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_AXIS   = 2'd0,
        REG_SIZE_X = 2'd1,
        REG_SIZE_Y = 2'd2,
        REG_SIZE_Z = 2'd3
    } cfg_reg_t;

    typedef enum logic [AXIS_BITS-1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } axis_t;

    // Saturate a size into MIN_SIZE..hi.
    function automatic logic [SZ_BITS-1:0] clamp_size(input logic [SZ_BITS-1:0] v,
                                                      input logic [SZ_BITS-1:0] hi);
        logic [SZ_BITS-1:0] r;
        if (v < SZ_BITS'(MIN_SIZE))
        begin
            r = SZ_BITS'(MIN_SIZE);
        end
        else if (v > hi)
        begin
            r = hi;
        end
        else
        begin
            r = v;
        end
        return r;
    endfunction

endpackage

### rtl/core/vcd_ram.sv
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Read-first on an address collision. No dependencies.
module vcd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 8192
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] ram_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            ram_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= ram_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### rtl/core/volume_central_difference.sv
// Streaming central-difference gradient of a 3D volume (top level).
// Depends on vcd_pkg, vcd_ram and volume_central_difference_defines.svh.
//
// Usage:
//   Samples enter in raster order (x fastest, then y, then z) on the sample
//   channel (sample_valid / sample_stall); one beat per voxel. For every voxel
//   with both neighbours along the chosen axis a result beat leaves on the
//   result channel (result_valid / result_stall): forward minus backward
//   neighbour with one fraction bit, the centre voxel's coordinates, and
//   volume_end on the last result of the volume. Edge voxels give no beat.
//   Configuration goes through cfg_valid / cfg_ready (always ready); any
//   write restarts the volume at the origin. Write only while idle.
// Timing:
//   One sample per cycle sustained unless back-pressure or a configuration
//   write stalls the sample channel. A result passes through the registered
//   delay-line read, then the subtract into the output register. The delay
//   line is a single one-write, one-read RAM of 2*MAX_ROW*MAX_ROWS entries,
//   touched once per beat. The sample channel stalls in the cycle after each
//   configuration write while the stride offset settles.
// Reset:
//   Counters, pointer and valids clear; axis returns to x, sizes to 64.
//   Delay-line contents are not cleared and need no clearing pass.
// Back-pressure:
//   When result_stall holds, the output register and one staged item hold;
//   back-pressure raises sample_stall only once both are occupied.
`include "volume_central_difference_defines.svh"

module volume_central_difference #(
    parameter int MAX_ROW     = vcd_pkg::MAX_ROW_DEF,
    parameter int MAX_ROWS    = vcd_pkg::MAX_ROWS_DEF,
    parameter int SAMPLE_BITS = vcd_pkg::SAMPLE_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    // configuration
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [vcd_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [vcd_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    // samples
    input  logic                                sample_valid,
    output logic                                sample_stall,
    input  logic signed [SAMPLE_BITS-1:0]       sample,
    // results
    output logic                                result_valid,
    input  logic                                result_stall,
    output logic signed [SAMPLE_BITS:0]         gradient,
    output logic [$clog2(MAX_ROW)-1:0]          pos_x,
    output logic [$clog2(MAX_ROWS)-1:0]         pos_y,
    output logic [vcd_pkg::Z_BITS-1:0]          pos_z,
    output logic                                volume_end
);

    import vcd_pkg::*;

    localparam int X_BITS      = $clog2(MAX_ROW);
    localparam int Y_BITS      = $clog2(MAX_ROWS);
    localparam int SX_BITS     = $clog2(MAX_ROW + 1);
    localparam int SY_BITS     = $clog2(MAX_ROWS + 1);
    localparam int DEPTH       = 2 * MAX_ROW * MAX_ROWS;
    localparam int ADDR_BITS   = $clog2(DEPTH);
    localparam int OFF_BITS    = ADDR_BITS + 1;
    localparam int STRIDE_BITS = $clog2(MAX_ROW * MAX_ROWS + 1);
    localparam int GRAD_BITS   = SAMPLE_BITS + 1;

    localparam logic [SZ_BITS-1:0] SX_RST =
        clamp_size(SZ_BITS'(SIZE_RESET), SZ_BITS'(MAX_ROW));
    localparam logic [SZ_BITS-1:0] SY_RST =
        clamp_size(SZ_BITS'(SIZE_RESET), SZ_BITS'(MAX_ROWS));
    localparam logic [SZ_BITS-1:0] SZ_RST =
        clamp_size(SZ_BITS'(SIZE_RESET), SZ_BITS'(PLANE_LIMIT));

    // ---------------------------------------------------------------
    // Configuration registers and derived constants
    // ---------------------------------------------------------------
    logic [AXIS_BITS-1:0]    axis_reg;
    logic [SIZE_XY_BITS-1:0] size_x_reg;
    logic [SIZE_XY_BITS-1:0] size_y_reg;
    logic [SZ_BITS-1:0]      size_z_reg;
    logic                    cfg_we;
    logic                    settle_reg;

    logic [SX_BITS-1:0]      sx_eff;
    logic [SY_BITS-1:0]      sy_eff;
    logic [SZ_BITS-1:0]      sz_eff;
    logic [SX_BITS+SY_BITS-1:0] plane;
    logic [STRIDE_BITS-1:0]  stride;
    logic [SX_BITS-1:0]      sx_m1_reg;
    logic [SY_BITS-1:0]      sy_m1_reg;
    logic [SZ_BITS-1:0]      sz_m1_reg;
    logic [OFF_BITS-1:0]     off_reg;
    logic [OFF_BITS-1:0]     off_next;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            axis_reg   <= AXIS_X;
            size_x_reg <= SIZE_XY_BITS'(SIZE_RESET);
            size_y_reg <= SIZE_XY_BITS'(SIZE_RESET);
            size_z_reg <= SZ_BITS'(SIZE_RESET);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_AXIS:   axis_reg   <= cfg_data[AXIS_BITS-1:0];
                REG_SIZE_X: size_x_reg <= cfg_data[SIZE_XY_BITS-1:0];
                REG_SIZE_Y: size_y_reg <= cfg_data[SIZE_XY_BITS-1:0];
                REG_SIZE_Z: size_z_reg <= cfg_data[SZ_BITS-1:0];
            endcase
        end
    end

    always_comb
    begin
        sx_eff = SX_BITS'(clamp_size(SZ_BITS'(size_x_reg), SZ_BITS'(MAX_ROW)));
        sy_eff = SY_BITS'(clamp_size(SZ_BITS'(size_y_reg), SZ_BITS'(MAX_ROWS)));
        sz_eff = clamp_size(size_z_reg, SZ_BITS'(PLANE_LIMIT));
        plane  = (SX_BITS+SY_BITS)'(sx_eff) * (SX_BITS+SY_BITS)'(sy_eff);
        unique case (axis_reg)
            AXIS_X:  stride = STRIDE_BITS'(1);
            AXIS_Y:  stride = STRIDE_BITS'(sx_eff);
            AXIS_Z:  stride = STRIDE_BITS'(plane);
            default: stride = STRIDE_BITS'(1);
        endcase
        // Read offset back two strides, modulo the delay-line depth.
        off_next = OFF_BITS'(DEPTH) - (OFF_BITS'(stride) << 1);
    end

    // Derived values are registered from the configuration registers and follow
    // them in the next cycle; settle_reg keeps samples out until they catch up.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sx_m1_reg  <= SX_BITS'(SX_RST - SZ_BITS'(1));
            sy_m1_reg  <= SY_BITS'(SY_RST - SZ_BITS'(1));
            sz_m1_reg  <= SZ_RST - SZ_BITS'(1);
            off_reg    <= OFF_BITS'(DEPTH - 2);
            settle_reg <= 1'b0;
        end
        else
        begin
            sx_m1_reg  <= sx_eff - SX_BITS'(1);
            sy_m1_reg  <= sy_eff - SY_BITS'(1);
            sz_m1_reg  <= sz_eff - SZ_BITS'(1);
            off_reg    <= off_next;
            settle_reg <= cfg_we;
        end
    end

    // ---------------------------------------------------------------
    // Handshake: output register, one staged item, sample intake
    // ---------------------------------------------------------------
    logic s1_valid_reg;
    logic out_valid_reg;
    logic out_move;
    logic s1_move;
    logic accept;

    assign out_move     = !out_valid_reg || !result_stall;
    assign s1_move      = out_move;
    assign sample_stall = settle_reg || (s1_valid_reg && !s1_move);
    assign accept       = sample_valid && !sample_stall;

    // ---------------------------------------------------------------
    // Stage 0: raster counters, delay-line addressing
    // ---------------------------------------------------------------
    logic [X_BITS-1:0]    cx_reg, cx_next;
    logic [Y_BITS-1:0]    cy_reg, cy_next;
    logic [Z_BITS-1:0]    cz_reg, cz_next;
    logic [ADDR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OFF_BITS-1:0]  rd_sum;
    logic [ADDR_BITS-1:0] rd_addr;
    logic                 last;
    logic                 emit;
    logic [X_BITS-1:0]    px;
    logic [Y_BITS-1:0]    py;
    logic [Z_BITS-1:0]    pz;

    always_comb
    begin
        last = (SX_BITS'(cx_reg) >= sx_m1_reg)
            && (SY_BITS'(cy_reg) >= sy_m1_reg)
            && (SZ_BITS'(cz_reg) >= sz_m1_reg);
        px   = cx_reg;
        py   = cy_reg;
        pz   = cz_reg;
        unique case (axis_reg)
            AXIS_X:
            begin
                emit = (cx_reg >= X_BITS'(2));
                px   = cx_reg - X_BITS'(1);
            end
            AXIS_Y:
            begin
                emit = (cy_reg >= Y_BITS'(2));
                py   = cy_reg - Y_BITS'(1);
            end
            AXIS_Z:
            begin
                emit = (cz_reg >= Z_BITS'(2));
                pz   = cz_reg - Z_BITS'(1);
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase

        rd_sum  = OFF_BITS'(wr_ptr_reg) + off_reg;
        rd_addr = (rd_sum >= OFF_BITS'(DEPTH)) ? ADDR_BITS'(rd_sum - OFF_BITS'(DEPTH))
                                               : ADDR_BITS'(rd_sum);

        wr_ptr_next = (wr_ptr_reg == ADDR_BITS'(DEPTH - 1)) ? '0
                                                            : wr_ptr_reg + ADDR_BITS'(1);

        // Advance the raster position; wrap to the origin after the last voxel.
        cx_next = cx_reg;
        cy_next = cy_reg;
        cz_next = cz_reg;
        if (last)
        begin
            cx_next = '0;
            cy_next = '0;
            cz_next = '0;
        end
        else if (SX_BITS'(cx_reg) < sx_m1_reg)
        begin
            cx_next = cx_reg + X_BITS'(1);
        end
        else
        begin
            cx_next = '0;
            if (SY_BITS'(cy_reg) < sy_m1_reg)
            begin
                cy_next = cy_reg + Y_BITS'(1);
            end
            else
            begin
                cy_next = '0;
                cz_next = cz_reg + Z_BITS'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cx_reg     <= '0;
            cy_reg     <= '0;
            cz_reg     <= '0;
            wr_ptr_reg <= '0;
        end
        else if (cfg_we)
        begin
            cx_reg <= '0;
            cy_reg <= '0;
            cz_reg <= '0;
        end
        else if (accept)
        begin
            cx_reg     <= cx_next;
            cy_reg     <= cy_next;
            cz_reg     <= cz_next;
            wr_ptr_reg <= wr_ptr_next;
        end
    end

    // Delay line: write the new sample, read the backward neighbour. When the
    // two strides span the full depth both hit one entry; read-first returns the old one.
    logic [SAMPLE_BITS-1:0] back_data;

    vcd_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (DEPTH)
    ) u_delay_line (
        .clk   (clk),
        .we    (accept),
        .waddr (wr_ptr_reg),
        .wdata (sample),
        .re    (accept),
        .raddr (rd_addr),
        .rdata (back_data)
    );

    // ---------------------------------------------------------------
    // Stage 1: forward sample waits for the read data
    // ---------------------------------------------------------------
    logic [SAMPLE_BITS-1:0] s1_cur_reg;
    logic [X_BITS-1:0]      s1_px_reg;
    logic [Y_BITS-1:0]      s1_py_reg;
    logic [Z_BITS-1:0]      s1_pz_reg;
    logic                   s1_last_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            s1_valid_reg <= emit;
        end
        else if (s1_move)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cur_reg  <= sample;
            s1_px_reg   <= px;
            s1_py_reg   <= py;
            s1_pz_reg   <= pz;
            s1_last_reg <= last;
        end
    end

    // ---------------------------------------------------------------
    // Output register: forward minus backward, read with one fraction bit
    // ---------------------------------------------------------------
    logic signed [GRAD_BITS-1:0] diff;
    logic signed [GRAD_BITS-1:0] gradient_reg;
    logic [X_BITS-1:0]           pos_x_reg;
    logic [Y_BITS-1:0]           pos_y_reg;
    logic [Z_BITS-1:0]           pos_z_reg;
    logic                        volume_end_reg;

    assign diff = $signed({s1_cur_reg[SAMPLE_BITS-1], s1_cur_reg})
                - $signed({back_data[SAMPLE_BITS-1], back_data});

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_move)
        begin
            out_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_move && s1_valid_reg)
        begin
            gradient_reg   <= diff;
            pos_x_reg      <= s1_px_reg;
            pos_y_reg      <= s1_py_reg;
            pos_z_reg      <= s1_pz_reg;
            volume_end_reg <= s1_last_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign gradient     = gradient_reg;
    assign pos_x        = pos_x_reg;
    assign pos_y        = pos_y_reg;
    assign pos_z        = pos_z_reg;
    assign volume_end   = volume_end_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    `VCD_ASSERT_NEXT(a_settle_after_cfg, cfg_we, sample_stall, "taken while settling")
    `VCD_ASSERT_SAME(a_no_overrun, s1_valid_reg && out_valid_reg && result_stall, !accept, "overrun")
    `VCD_ASSERT_SAME(a_rd_wr_apart, accept && (off_reg != '0), rd_addr != wr_ptr_reg, "collision")
    `VCD_ASSERT_SAME(a_cx_in_range, 1'b1, SX_BITS'(cx_reg) <= sx_m1_reg, "x counter beyond size")
    `VCD_ASSERT_SAME(a_cy_in_range, 1'b1, SY_BITS'(cy_reg) <= sy_m1_reg, "y counter beyond size")

endmodule

### verif/testbench.sv
// Self-checking testbench for the volume central-difference gradient block.
// Depends on vcd_pkg and the volume_central_difference RTL; reads no files.
`timescale 1ns / 1ps

module testbench;
    import vcd_pkg::*;

    localparam int SAMPLE_W       = SAMPLE_BITS_DEF;
    localparam int GRAD_W         = SAMPLE_W + 1;
    localparam int LINE_DEPTH     = 2 * MAX_ROW_DEF * MAX_ROWS_DEF;
    localparam int SETTLE_CYCLES  = 8;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int RANDOM_VOXELS  = 400;
    localparam int VOLUME_CAP     = 150;

    // No result leaves the block while this axis code is programmed.
    localparam logic [AXIS_BITS-1:0] AXIS_NONE = 2'd3;

    localparam logic signed [SAMPLE_W-1:0] MOST_NEG = {1'b1, {(SAMPLE_W-1){1'b0}}};
    localparam logic signed [SAMPLE_W-1:0] MOST_POS = ~MOST_NEG;

    typedef struct packed {
        logic signed [GRAD_W-1:0] gradient;
        logic [5:0]               pos_x;
        logic [5:0]               pos_y;
        logic [Z_BITS-1:0]        pos_z;
        logic                     volume_end;
    } gradient_beat_t;

    typedef struct packed {
        cfg_reg_t                 idx;
        logic [CFG_DATA_BITS-1:0] data;
    } reg_write_t;

    // Clock, reset and block ports; every input is known from time zero.
    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data  = '0;

    logic                       sample_valid = 1'b0;
    logic                       sample_stall;
    logic signed [SAMPLE_W-1:0] sample = '0;

    logic                     result_valid;
    logic                     result_stall = 1'b0;
    logic signed [GRAD_W-1:0] gradient;
    logic [5:0]               pos_x;
    logic [5:0]               pos_y;
    logic [Z_BITS-1:0]        pos_z;
    logic                     volume_end;

    // Shared testbench state.
    gradient_beat_t pending_gradients[$];
    reg_write_t     queued_writes[$];
    int             mismatch_count = 0;
    int             idle_cycles    = 0;
    int             stall_left     = 0;
    bit             idling_on      = 1'b1;

    // Predictor state: the raster counters, the circular delay line and its
    // write pointer, and the programmed registers as the block holds them.
    logic signed [SAMPLE_W-1:0] line_mem [LINE_DEPTH];
    int unsigned                wr_index = 0;
    int unsigned                cnt_x    = 0;
    int unsigned                cnt_y    = 0;
    int unsigned                cnt_z    = 0;
    logic [AXIS_BITS-1:0]       cfg_axis   = AXIS_X;
    logic [SIZE_XY_BITS-1:0]    cfg_size_x = SIZE_XY_BITS'(SIZE_RESET);
    logic [SIZE_XY_BITS-1:0]    cfg_size_y = SIZE_XY_BITS'(SIZE_RESET);
    logic [SZ_BITS-1:0]         cfg_size_z = SZ_BITS'(SIZE_RESET);

    volume_central_difference dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .sample_valid (sample_valid),
        .sample_stall (sample_stall),
        .sample       (sample),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .gradient     (gradient),
        .pos_x        (pos_x),
        .pos_y        (pos_y),
        .pos_z        (pos_z),
        .volume_end   (volume_end)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------

    // Saturate a programmed size into the range the block can handle.
    function automatic int unsigned bound_size(input int unsigned raw, input int unsigned top);
        if (raw < MIN_SIZE)
            return MIN_SIZE;
        if (raw > top)
            return top;
        return raw;
    endfunction

    function automatic int unsigned volume_voxels();
        return bound_size(32'(cfg_size_x), MAX_ROW_DEF) * bound_size(32'(cfg_size_y), MAX_ROWS_DEF)
               * bound_size(32'(cfg_size_z), PLANE_LIMIT);
    endfunction

    // Mirror a register write: mask to the register width, restart the raster.
    // The delay line and its pointer carry over untouched.
    task automatic record_register(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        case (idx)
            REG_AXIS:   cfg_axis   = data[AXIS_BITS-1:0];
            REG_SIZE_X: cfg_size_x = data[SIZE_XY_BITS-1:0];
            REG_SIZE_Y: cfg_size_y = data[SIZE_XY_BITS-1:0];
            default:    cfg_size_z = data;
        endcase
        cnt_x = 0;
        cnt_y = 0;
        cnt_z = 0;
    endtask

    // Each accepted voxel is the forward neighbour of the voxel one stride
    // back; when that centre voxel has a backward neighbour too, queue the
    // gradient beat the block owes for it, then store the voxel and advance.
    task automatic predict_gradient(input logic signed [SAMPLE_W-1:0] value);
        int unsigned    sx;
        int unsigned    sy;
        int unsigned    sz;
        int unsigned    stride;
        int unsigned    coord;
        int unsigned    rd;
        logic           at_end;
        gradient_beat_t beat;
        sx     = bound_size(32'(cfg_size_x), MAX_ROW_DEF);
        sy     = bound_size(32'(cfg_size_y), MAX_ROWS_DEF);
        sz     = bound_size(32'(cfg_size_z), PLANE_LIMIT);
        at_end = (cnt_x >= sx - 1) && (cnt_y >= sy - 1) && (cnt_z >= sz - 1);
        stride = 0;
        coord  = 0;
        case (cfg_axis)
            AXIS_X:
            begin
                stride = 1;
                coord  = cnt_x;
            end
            AXIS_Y:
            begin
                stride = sx;
                coord  = cnt_y;
            end
            AXIS_Z:
            begin
                stride = sx * sy;
                coord  = cnt_z;
            end
            default:
            begin
                stride = 0;
            end
        endcase
        if (stride != 0 && coord >= 2)
        begin
            rd                = (wr_index + LINE_DEPTH - 2 * stride) % LINE_DEPTH;
            beat.gradient     = GRAD_W'(int'(value) - int'(line_mem[rd]));
            beat.pos_x        = 6'(cnt_x - ((cfg_axis == AXIS_X) ? 1 : 0));
            beat.pos_y        = 6'(cnt_y - ((cfg_axis == AXIS_Y) ? 1 : 0));
            beat.pos_z        = Z_BITS'(cnt_z - ((cfg_axis == AXIS_Z) ? 1 : 0));
            beat.volume_end   = at_end;
            pending_gradients.push_back(beat);
        end
        line_mem[wr_index] = value;
        wr_index           = (wr_index + 1) % LINE_DEPTH;
        if (at_end)
        begin
            cnt_x = 0;
            cnt_y = 0;
            cnt_z = 0;
        end
        else if (cnt_x + 1 < sx)
            cnt_x = cnt_x + 1;
        else
        begin
            cnt_x = 0;
            if (cnt_y + 1 < sy)
                cnt_y = cnt_y + 1;
            else
            begin
                cnt_y = 0;
                cnt_z = cnt_z + 1;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Sender side
    // ------------------------------------------------------------------

    // Bias towards the two rails, zero and minus one; otherwise fully random.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample();
        case ($urandom_range(0, 15))
            0:       return MOST_NEG;
            1:       return MOST_POS;
            2:       return '0;
            3:       return '1;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    // Present one voxel, hold it until the block takes the beat, then predict.
    // Valid stays high into the next call unless an idle burst drops it.
    task automatic send_voxel(input logic signed [SAMPLE_W-1:0] value);
        int unsigned gap;
        sample_valid <= 1'b1;
        sample       <= value;
        do
            @(posedge clk);
        while (sample_stall);
        predict_gradient(value);
        if (idling_on && $urandom_range(0, 11) == 0)
        begin
            gap = $urandom_range(1, 19);
            sample_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic send_random_voxels(input int unsigned count);
        repeat (count) send_voxel(pick_sample());
    endtask

    // Drop valid and wait until every owed beat has come back, then give a
    // voxel that owes nothing time to clear the two-stage pipeline.
    task automatic wait_for_drain();
        sample_valid <= 1'b0;
        while (pending_gradients.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic queue_write(input cfg_reg_t idx, input logic [CFG_DATA_BITS-1:0] data);
        reg_write_t w;
        w.idx  = idx;
        w.data = data;
        queued_writes.push_back(w);
    endtask

    // Configuration only goes in while the block is idle; back-to-back beats
    // keep cfg_valid high and only the last one drops it.
    task automatic commit_register_writes();
        reg_write_t w;
        wait_for_drain();
        while (queued_writes.size() != 0)
        begin
            w = queued_writes.pop_front();
            cfg_valid <= 1'b1;
            cfg_index <= w.idx;
            cfg_data  <= w.data;
            do
                @(posedge clk);
            while (!cfg_ready);
            record_register(w.idx, w.data);
        end
        cfg_valid <= 1'b0;
    endtask

    task automatic program_volume(input logic [AXIS_BITS-1:0] axis_code,
                                  input int unsigned sx,
                                  input int unsigned sy,
                                  input int unsigned sz);
        queue_write(REG_AXIS, CFG_DATA_BITS'(axis_code));
        queue_write(REG_SIZE_X, CFG_DATA_BITS'(sx));
        queue_write(REG_SIZE_Y, CFG_DATA_BITS'(sy));
        queue_write(REG_SIZE_Z, CFG_DATA_BITS'(sz));
        commit_register_writes();
    endtask

    // ------------------------------------------------------------------
    // Receiver side: random stall bursts, then field-by-field comparison
    // ------------------------------------------------------------------

    always @(posedge clk)
    begin
        if (stall_left == 0 && idling_on && $urandom_range(0, 13) == 0)
            stall_left = $urandom_range(1, 19);
        if (stall_left != 0)
        begin
            result_stall <= 1'b1;
            stall_left = stall_left - 1;
        end
        else
            result_stall <= 1'b0;
    end

    task automatic compare_field(input string field, input int want, input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
            mismatch_count++;
        end
    endtask

    always @(posedge clk)
    begin
        gradient_beat_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            if (pending_gradients.size() == 0)
            begin
                $display("%0t: unexpected result beat: expected none, %s (%0d,%0d,%0d) end %0d",
                         $time, $sformatf("got gradient %0d at", gradient),
                         pos_x, pos_y, pos_z, volume_end);
                mismatch_count++;
            end
            else
            begin
                want = pending_gradients.pop_front();
                compare_field("gradient", int'($signed(want.gradient)), int'(gradient));
                compare_field("pos_x", int'(want.pos_x), int'(pos_x));
                compare_field("pos_y", int'(want.pos_y), int'(pos_y));
                compare_field("pos_z", int'(want.pos_z), int'(pos_z));
                compare_field("volume_end", int'(want.volume_end), int'(volume_end));
            end
        end
    end

    // Watchdog: end the run if no beat moves on any channel for too long.
    always @(posedge clk)
    begin
        if ((sample_valid && !sample_stall) || (result_valid && !result_stall)
            || (cfg_valid && cfg_ready))
            idle_cycles = 0;
        else
        begin
            idle_cycles = idle_cycles + 1;
            if (idle_cycles == WATCHDOG_LIMIT)
            begin
                $display("%0t: timeout, no beat accepted for %0d cycles", $time, WATCHDOG_LIMIT);
                $display("** volume_central_difference: FAILED **");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Stream with the reset settings: x axis over 64-sample rows.
    task automatic test_reset_defaults();
        send_random_voxels(200);
    endtask

    // Smallest volume along x with the sample rails at both ends of two rows
    // in three, so the gradient reaches both of its extremes; run one row past
    // the end of the volume to see the raster wrap to the origin.
    task automatic test_extremes();
        logic signed [SAMPLE_W-1:0] lead;
        logic signed [SAMPLE_W-1:0] trail;
        program_volume(AXIS_X, 3, 3, 3);
        for (int row = 0; row < 9; row++)
        begin
            case (row % 3)
                0:
                begin
                    lead  = MOST_NEG;
                    trail = MOST_POS;
                end
                1:
                begin
                    lead  = MOST_POS;
                    trail = MOST_NEG;
                end
                default:
                begin
                    lead  = '1;
                    trail = '0;
                end
            endcase
            send_voxel(lead);
            send_voxel(pick_sample());
            send_voxel(trail);
        end
        send_random_voxels(3);
    endtask

    // Undersized and oversized sizes saturate; high data bits beyond a
    // register's width are dropped.
    task automatic test_size_clamp();
        program_volume(AXIS_Y, 0, 2, 1);
        send_random_voxels(volume_voxels() + 5);
        program_volume(AXIS_Y, 13'h1FFF, 13'h1F83, 0);
        send_random_voxels(200);
    endtask

    // Axis three stores voxels but emits nothing; a lone axis write part way
    // through a volume restarts the raster at the origin.
    task automatic test_axis_three_and_restart();
        program_volume(AXIS_NONE, 3, 3, 3);
        send_random_voxels(40);
        queue_write(REG_AXIS, CFG_DATA_BITS'(AXIS_X));
        commit_register_writes();
        send_random_voxels(27);
    endtask

    // Hold the sender half way through a volume until every owed beat is
    // back, then carry on with the same volume.
    task automatic test_pressure_pause();
        program_volume(AXIS_Y, 5, 4, 4);
        send_random_voxels(40);
        wait_for_drain();
        send_random_voxels(40);
    endtask

    // Wide strides: a plane of full-width rows back along z, with the row
    // width saturated to its limit, run to the end of the volume.
    task automatic test_wide_strides();
        program_volume(AXIS_Z, 13'h1FFF, 3, 3);
        send_random_voxels(volume_voxels());
    endtask

    // Random volumes: mostly small and complete (often two in a row to cross
    // the end of a volume), some cut short, some with out-of-range sizes.
    task automatic test_random_volumes();
        int unsigned          random_voxels;
        int unsigned          count;
        logic [AXIS_BITS-1:0] axis_code;
        int unsigned          sx;
        int unsigned          sy;
        int unsigned          sz;
        random_voxels = 0;
        while (random_voxels < RANDOM_VOXELS)
        begin
            axis_code = ($urandom_range(0, 9) == 0) ? AXIS_NONE : AXIS_BITS'($urandom_range(0, 2));
            sx = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 8);
            sy = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(3, 8);
            sz = ($urandom_range(0, 5) == 0) ? $urandom_range(0, 8191) : $urandom_range(3, 6);
            program_volume(axis_code, sx, sy, sz);
            idling_on = ($urandom_range(0, 3) != 0);
            count = volume_voxels();
            if ($urandom_range(0, 2) == 0)
                count = $urandom_range(1, count);
            else if ($urandom_range(0, 1) == 0)
                count = 2 * count;
            if (count > VOLUME_CAP)
                count = $urandom_range(1, VOLUME_CAP);
            send_random_voxels(count);
            random_voxels += count;
        end
        idling_on = 1'b1;
    endtask

    // A narrow volume several dozen planes deep, run to its end with no
    // idling at all, so the last part of the run moves beats back to back.
    task automatic test_deep_volume();
        idling_on = 1'b0;
        program_volume(AXIS_X, 3, 3, 36);
        send_random_voxels(volume_voxels());
    endtask

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_extremes();
        test_size_clamp();
        test_axis_three_and_restart();
        test_pressure_pause();
        test_wide_strides();
        test_random_volumes();
        test_deep_volume();
        wait_for_drain();
        if (mismatch_count == 0)
            $display("** volume_central_difference: PASSED **");
        else
            $display("** volume_central_difference: FAILED **");
        $finish;
    end

endmodule

### files.f
+incdir+rtl/core
rtl/core/vcd_pkg.sv
rtl/core/vcd_ram.sv
rtl/core/volume_central_difference.sv
verif/testbench.sv
